/* hdl/pwwd_pkg.sv */
// Shared types and constants for the pulse width weather packet decoder.
package pwwd_pkg;

   localparam int unsigned PktBits   = 36;
   localparam int unsigned DurBits   = 16;
   localparam int unsigned CsrIdxBits = 2;

   localparam logic [CsrIdxBits-1:0] RegOneThreshold  = 2'd0;
   localparam logic [CsrIdxBits-1:0] RegZeroThreshold = 2'd1;

   localparam logic [DurBits-1:0] OneThresholdReset  = 16'd1500;
   localparam logic [DurBits-1:0] ZeroThresholdReset = 16'd650;

   localparam logic [7:0] HumMin = 8'd5;
   localparam logic [7:0] HumMax = 8'd100;
   localparam logic signed [11:0] TempMin = -12'sd400;
   localparam logic signed [11:0] TempMax = 12'sd900;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_HUM  = 2'd1,
      STATUS_BAD_TEMP = 2'd2
   } status_type;

   typedef struct packed {
      logic [DurBits-1:0] one_threshold;
      logic [DurBits-1:0] zero_threshold;
   } thresholds_type;

   typedef struct packed {
      logic [PktBits-1:0] raw_bits;
      logic [7:0]         sensor_id;
      logic               battery_flag;
      logic [2:0]         channel;
      logic signed [11:0] temperature_tenths;
      logic [7:0]         humidity;
      status_type         status;
   } result_type;

endpackage

/* hdl/pwwd_classify.sv */
// Pulse classification and next value of the packet shift register.
module pwwd_classify (
   input  logic [pwwd_pkg::PktBits-1:0] shift_bits,
   input  logic [pwwd_pkg::DurBits-1:0] duration,
   input  logic                         start_of_packet,
   input  pwwd_pkg::thresholds_type     thresholds,
   output logic [pwwd_pkg::PktBits-1:0] shift_bits_next
);
   import pwwd_pkg::*;

   always_comb begin
      if (start_of_packet) begin
         shift_bits_next = '0;
      end else if (duration > thresholds.one_threshold) begin
         shift_bits_next = {shift_bits[PktBits-2:0], 1'b1};
      end else if (duration > thresholds.zero_threshold) begin
         shift_bits_next = {shift_bits[PktBits-2:0], 1'b0};
      end else begin
         // too short: drop
         shift_bits_next = shift_bits;
      end
   end

endmodule

/* hdl/pwwd_decode.sv */
// Field extraction and range checks on an assembled packet.
module pwwd_decode (
   input  logic [pwwd_pkg::PktBits-1:0] packet,
   output pwwd_pkg::result_type         result
);
   import pwwd_pkg::*;

   logic [7:0]         hum;
   logic signed [11:0] temp;
   logic               hum_bad;
   logic               temp_bad;

   assign hum      = packet[7:0];
   assign temp     = packet[23:12];
   assign hum_bad  = (hum != 8'd0) && ((hum > HumMax) || (hum < HumMin));
   assign temp_bad = (temp < TempMin) || (temp > TempMax);

   always_comb begin
      result.raw_bits           = packet;
      result.sensor_id          = packet[35:28];
      result.battery_flag       = packet[27];
      result.channel            = {1'b0, packet[25:24]} + 3'd1;
      result.temperature_tenths = temp;
      result.humidity           = hum;
      if (hum_bad) begin
         result.status = STATUS_BAD_HUM;
      end else if (temp_bad) begin
         result.status = STATUS_BAD_TEMP;
      end else begin
         result.status = STATUS_OK;
      end
   end

endmodule

/* hdl/pulse_width_weather_packet_decoder_top.sv */
// Top level of the pulse width weather packet decoder.
//
// Usage:
//  - req_ channel: one measured pulse gap per transfer. req_tdata holds the
//    duration, req_tuser marks the first item of a packet (clears the shift
//    register, duration ignored), req_tlast marks the last item.
//  - rsp_ channel: one decoded sensor reading per packet, sent after the
//    item carrying req_tlast has been classified.
//  - csr_ channel: index 0 writes the one threshold, index 1 the zero
//    threshold; other indexes are ignored. csr_ready is always high.
//    Write only while the block is idle.
// Timing: an item is taken into an input register, then classified and
//  decoded into the result register once that register is free.
//  One item per cycle is sustained while no result waits on rsp_tready;
//  the limit is the single shift register update per cycle.
// Reset: clears both pipeline valids and the shift register and loads the
//  default thresholds (1500 and 650).
// Stall: while a result waits with rsp_tready low, hold it; the input
//  register still fills once, then req_tready drops until the result leaves.
module pulse_width_weather_packet_decoder_top (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] duration
   input  logic        req_tuser,   // [0] start_of_packet
   input  logic        req_tlast,   // end_of_packet
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [35:0] raw_bits, [43:36] sensor_id, [44] battery_flag, [47:45] channel,
   // [59:48] temperature_tenths, [67:60] humidity, [71:68] zero
   output logic [71:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // [1:0] status
   // configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import pwwd_pkg::*;

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic [DurBits-1:0]   in_dur_ff;
   logic                 in_start_ff;
   logic                 in_end_ff;

   // packet state and thresholds
   logic [PktBits-1:0]   shift_ff, shift_in;
   thresholds_type       thr_ff, thr_in;

   // result register
   logic                 out_valid_ff, out_valid_in;
   result_type           out_ff;
   result_type           decoded;

   logic                 out_free;
   logic                 advance;
   logic                 req_xfer;

   // the result register can take a new value this cycle
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   pwwd_classify u_classify (
      .shift_bits      (shift_ff),
      .duration        (in_dur_ff),
      .start_of_packet (in_start_ff),
      .thresholds      (thr_ff),
      .shift_bits_next (shift_in)
   );

   // decode from the freshly updated packet
   pwwd_decode u_decode (
      .packet (shift_in),
      .result (decoded)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = in_end_ff;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_comb begin
      thr_in = thr_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            RegOneThreshold:  thr_in.one_threshold  = csr_data;
            RegZeroThreshold: thr_in.zero_threshold = csr_data;
            default:          thr_in = thr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         shift_ff     <= '0;
         thr_ff       <= '{one_threshold: OneThresholdReset,
                           zero_threshold: ZeroThresholdReset};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         thr_ff       <= thr_in;
         if (advance) begin
            shift_ff <= shift_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_dur_ff   <= req_tdata;
         in_start_ff <= req_tuser;
         in_end_ff   <= req_tlast;
      end
      if (advance && in_end_ff) begin
         out_ff <= decoded;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000,
                        out_ff.humidity,
                        out_ff.temperature_tenths,
                        out_ff.channel,
                        out_ff.battery_flag,
                        out_ff.sensor_id,
                        out_ff.raw_bits};
   assign rsp_tuser  = out_ff.status;

   // a start item always leaves an empty packet behind
   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      advance && in_start_ff |=> shift_ff == '0)
      else $error("shift register not cleared by start item");

   // a result only appears from an end item moving out of the input register
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(advance) && $past(in_end_ff))
      else $error("result without end item");

   // the packet state moves only when an item moves on
   a_shift_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(shift_ff))
      else $error("shift register changed without an item");

   // decoded channel is never zero and status never the unused code
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_ff.channel != 3'd0) && (rsp_tuser != 2'd3))
      else $error("decoded result out of range");

   // input register is full whenever the request side is held off
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && rsp_tvalid && !rsp_tready)
      else $error("request held off without cause");

endmodule

/* tb/sv/pulse_width_weather_packet_decoder_top_tb.sv */
// Self-checking testbench for the pulse width weather packet decoder top level.
`timescale 1ns / 100ps

module pulse_width_weather_packet_decoder_top_tb;
   import pwwd_pkg::*;

   // Spare register indexes: writes to them must be ignored by the block
   localparam logic [CsrIdxBits-1:0] RegSpareLow  = 2'd2;
   localparam logic [CsrIdxBits-1:0] RegSpareHigh = 2'd3;

   // Abort the run if it has not finished by this many clock cycles
   localparam int unsigned CycleLimit = 200000;
   // Allow for the two-stage pipeline plus margin before touching the registers
   localparam int unsigned SettleCycles = 6;

   // Mirrors the decoder: thresholds, shift register and the readings still owed
   class weather_reading_board;
      logic [PktBits-1:0] shift_bits;
      logic [DurBits-1:0] one_thr;
      logic [DurBits-1:0] zero_thr;
      result_type         pending_readings[$];
      int unsigned        n_predicted;
      int unsigned        n_errors;

      function new();
         shift_bits  = '0;
         one_thr     = OneThresholdReset;
         zero_thr    = ZeroThresholdReset;
         n_predicted = 0;
         n_errors    = 0;
      endfunction

      function void write_reg(logic [CsrIdxBits-1:0] index, logic [DurBits-1:0] value);
         case (index)
            RegOneThreshold:  one_thr  = value;
            RegZeroThreshold: zero_thr = value;
            default: ;
         endcase
      endfunction

      // Classify one accepted pulse and queue the reading if it closes a packet
      function void take_pulse(logic [DurBits-1:0] dur, logic start, logic last);
         result_type         r;
         logic signed [11:0] temp;
         logic [7:0]         hum;
         if (start) begin
            shift_bits = '0;
         end else if (dur > one_thr) begin
            shift_bits = {shift_bits[PktBits-2:0], 1'b1};
         end else if (dur > zero_thr) begin
            shift_bits = {shift_bits[PktBits-2:0], 1'b0};
         end
         if (!last) return;
         temp = shift_bits[23:12];
         hum  = shift_bits[7:0];
         r.raw_bits           = shift_bits;
         r.sensor_id          = shift_bits[35:28];
         r.battery_flag       = shift_bits[27];
         r.channel            = {1'b0, shift_bits[25:24]} + 3'd1;
         r.temperature_tenths = temp;
         r.humidity           = hum;
         // humidity fault outranks temperature fault; zero humidity is accepted
         if (hum != 8'd0 && (hum > HumMax || hum < HumMin)) begin
            r.status = STATUS_BAD_HUM;
         end else if (temp < TempMin || temp > TempMax) begin
            r.status = STATUS_BAD_TEMP;
         end else begin
            r.status = STATUS_OK;
         end
         pending_readings.push_back(r);
         n_predicted++;
      endfunction

      function void compare(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_errors++;
         end
      endfunction

      function void check_reading(logic [71:0] data, logic [1:0] user);
         result_type e;
         if (pending_readings.size() == 0) begin
            $error("reading with none outstanding: tdata %h tuser %h", data, user);
            n_errors++;
            return;
         end
         e = pending_readings.pop_front();
         compare("raw_bits", 64'(e.raw_bits), 64'(data[35:0]));
         compare("sensor_id", 64'(e.sensor_id), 64'(data[43:36]));
         compare("battery_flag", 64'(e.battery_flag), 64'(data[44]));
         compare("channel", 64'(e.channel), 64'(data[47:45]));
         compare("temperature_tenths", {52'd0, e.temperature_tenths}, 64'(data[59:48]));
         compare("humidity", 64'(e.humidity), 64'(data[67:60]));
         compare("padding", 64'd0, 64'(data[71:68]));
         compare("status", 64'(e.status), 64'(user));
      endfunction

      function int unsigned outstanding();
         return pending_readings.size();
      endfunction
   endclass

   typedef bit bool_tail_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;

   weather_reading_board board;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned items_sent;
   int unsigned cycles;

   pulse_width_weather_packet_decoder_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 12 ns period, low for the first half
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Receiver: stall at the configured rate, decided once per falling edge
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Check every reading the moment its transfer completes
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_reading(rsp_tdata, rsp_tuser);
      end
   end

   // Watchdog: a hang anywhere ends the run as a failure
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Write one register; the model only follows once the transfer has happened
   task automatic csr_write(logic [CsrIdxBits-1:0] index, logic [DurBits-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(index, value);
      @(negedge clock);
      csr_valid = 1'b0;
      @(posedge clock);
   endtask

   // Offer one pulse, idling beforehand at the sender rate; return after the transfer
   task automatic send_pulse(logic [DurBits-1:0] dur, logic start, logic last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = dur;
      req_tuser  = start;
      req_tlast  = last;
      do @(posedge clock); while (!req_tready);
      board.take_pulse(dur, start, last);
      items_sent++;
   endtask

   // Drop the valid and hold off until every owed reading has come out
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Durations that the current thresholds turn into a one, a zero or nothing.
   // Where a class cannot occur under the current settings, any duration goes.
   function automatic logic [DurBits-1:0] one_pulse();
      if (board.one_thr == 16'hFFFF) return DurBits'($urandom);
      return DurBits'($urandom_range(16'hFFFF, board.one_thr + 1));
   endfunction

   function automatic logic [DurBits-1:0] zero_pulse();
      if (board.zero_thr >= board.one_thr) return DurBits'($urandom);
      return DurBits'($urandom_range(board.one_thr, board.zero_thr + 1));
   endfunction

   function automatic logic [DurBits-1:0] dropped_pulse();
      if (board.zero_thr < board.one_thr) return DurBits'($urandom_range(board.zero_thr, 0));
      return DurBits'($urandom_range(board.one_thr, 0));
   endfunction

   // Anything at all, with extra weight right on either threshold
   function automatic logic [DurBits-1:0] noise_pulse();
      case ($urandom_range(3))
         0: return board.one_thr + DurBits'($urandom_range(2)) - 16'd1;
         1: return board.zero_thr + DurBits'($urandom_range(2)) - 16'd1;
         default: return DurBits'($urandom);
      endcase
   endfunction

   // Build a plausible sensor frame: mostly in-range readings, some faulty
   function automatic logic [PktBits-1:0] sensor_frame();
      logic [PktBits-1:0] f;
      f = PktBits'({$urandom, $urandom});
      if ($urandom_range(99) < 80) begin
         f[23:12] = 12'($urandom_range(1300)) - 12'd400;
      end
      if ($urandom_range(99) < 80) begin
         f[7:0] = 8'($urandom_range(100, 5));
      end
      return f;
   endfunction

   // One packet: mostly well-formed frames, some overlong, some plain noise
   task automatic send_packet();
      logic [PktBits-1:0] frame;
      int unsigned        kind;
      int unsigned        n;
      bool_tail_t         tail;
      kind = $urandom_range(99);
      if (kind < 70) begin
         frame = sensor_frame();
         tail  = ($urandom_range(9) == 0);
         send_pulse(DurBits'($urandom), 1'b1, 1'b0);
         for (int b = PktBits - 1; b >= 0; b--) begin
            // sprinkle short gaps that the decoder must skip
            if ($urandom_range(9) == 0) send_pulse(dropped_pulse(), 1'b0, 1'b0);
            send_pulse(frame[b] ? one_pulse() : zero_pulse(), 1'b0, b == 0 && !tail);
         end
         if (tail) send_pulse(dropped_pulse(), 1'b0, 1'b1);
      end else if (kind < 85) begin
         // more bits than the register holds: the oldest must fall off the top
         n = PktBits + $urandom_range(8, 1);
         send_pulse(DurBits'($urandom), 1'b1, 1'b0);
         for (int i = 0; i < n; i++) begin
            send_pulse($urandom_range(1) ? one_pulse() : zero_pulse(), 1'b0, i == n - 1);
         end
      end else begin
         n = $urandom_range(45);
         for (int i = 0; i < n; i++) begin
            send_pulse(noise_pulse(), $urandom_range(99) < 8,
                       $urandom_range(99) < 8 || (i == n - 1 && $urandom_range(1)));
         end
      end
   endtask

   // Before any start flag, then start and end on one item, then a short packet
   task automatic directed_pulses();
      send_pulse(16'hFFFF, 1'b0, 1'b0);   // one
      send_pulse(16'h0000, 1'b0, 1'b0);   // dropped
      send_pulse(16'd650,  1'b0, 1'b0);   // on the zero threshold: dropped
      send_pulse(16'd651,  1'b0, 1'b0);   // zero
      send_pulse(16'd1500, 1'b0, 1'b0);   // on the one threshold: still a zero
      send_pulse(16'd1501, 1'b0, 1'b1);   // one, closes the packet
      send_pulse(16'hFFFF, 1'b1, 1'b1);   // start and end together: empty packet
      send_pulse(16'h0000, 1'b1, 1'b0);   // start ignores its own duration
      send_pulse(16'hFFFF, 1'b0, 1'b0);
      send_pulse(16'h8000, 1'b0, 1'b0);
      send_pulse(16'h0001, 1'b0, 1'b1);   // dropped end item still emits
      send_pulse(16'h7FFF, 1'b1, 1'b0);   // lone start, then an end after it
      send_pulse(16'h5555, 1'b0, 1'b1);
      send_pulse(16'hAAAA, 1'b0, 1'b1);   // end without a start: builds on the last
   endtask

   logic [DurBits-1:0] one_settings  [12];
   logic [DurBits-1:0] zero_settings [12];

   initial begin
      int unsigned base_items;
      int unsigned base_readings;
      int unsigned step;
      board         = new();
      cycles        = 0;
      items_sent    = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = 1'b0;
      req_tlast     = 1'b0;
      rsp_tready    = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;

      // Threshold pairs: defaults, the extremes, a swapped pair and random ones
      one_settings  = '{16'd1500, 16'd1000, 16'hFFFF, 16'd0, 16'd300, 16'd1500,
                        16'd60000, 16'd0, 16'hFFFF, 16'($urandom), 16'($urandom), 16'd1500};
      zero_settings = '{16'd650, 16'd400, 16'd0, 16'hFFFF, 16'd40000, 16'd650,
                        16'd20000, 16'd0, 16'hFFFF, 16'($urandom), 16'($urandom), 16'd650};

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(posedge clock);

      // Spare indexes must leave both thresholds alone
      csr_write(RegSpareLow, 16'($urandom));
      csr_write(RegSpareHigh, 16'hFFFF);
      csr_write(RegOneThreshold, OneThresholdReset);
      csr_write(RegZeroThreshold, ZeroThresholdReset);

      // Sender rarely idle, receiver mostly stalled; then the reverse; then flat out
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 66 : 0;
         recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 7 : 0;
         if (phase == 0) directed_pulses();
         for (int c = 0; c < 4; c++) begin
            step = phase * 4 + c;
            // registers change only once the block has gone quiet
            drain();
            csr_write(RegOneThreshold, one_settings[step]);
            csr_write(RegZeroThreshold, zero_settings[step]);
            base_items    = items_sent;
            base_readings = board.n_predicted;
            while (items_sent - base_items < 40 || board.n_predicted == base_readings) begin
               send_packet();
            end
         end
      end

      drain();
      if (board.n_errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
